// ----- design/tkst_pkg.sv -----
`default_nettype none
package tkst_pkg;

  // fixed field widths of the stream words
  localparam int DATA_W  = 16;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // defaults for the top level parameters
  localparam int TABLE_DEPTH_DEF = 14;
  localparam int VALUE_WIDTH_DEF = 16;

  // item kind carried in tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/top_k_score_table_top.sv -----
// flow: a word is accepted in the idle state and loaded into the input registers; the run
//   state then updates the table and fills the result register before a new word is taken;
//   a result not yet taken holds the update of the next word until it leaves
// reset: synchronous active-low rst_n empties the table and drops any result;
//   table contents are not cleared, entries past the count are never read
`default_nettype none
module top_k_score_table_top #(
  parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = tkst_pkg::VALUE_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [tkst_pkg::IN_TDATA_W-1:0]     in_tdata,   // new_value, read_rank
  input  wire                                in_tuser,   // kind
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [tkst_pkg::OUT_TDATA_W-1:0]   out_tdata   // kept, entry_count, ranked_value,
                                                         // ranked_valid
);
  import tkst_pkg::*;

  cmd_t               cmd;
  logic               kept;
  logic [COUNT_W-1:0] count;
  logic [DATA_W-1:0]  value;
  logic               rvalid;

  tkst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tkst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_tuser),
    .in_value   (in_tdata[DATA_W-1:0]),
    .in_rank    (in_tdata[DATA_W+RANK_W-1:DATA_W]),
    .out_kept   (kept),
    .out_count  (count),
    .out_value  (value),
    .out_rvalid (rvalid)
  );

  assign out_tdata = {2'b00, rvalid, value, count, kept};

endmodule
`default_nettype wire

// ----- design/tkst_ctrl.sv -----
`default_nettype none
module tkst_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire             out_tready,
  output tkst_pkg::cmd_t  cmd
);
  import tkst_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load_in   = 1'b0;
    cmd.exec      = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        // update the table only once the result register can take the word
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/tkst_dp.sv -----
`default_nettype none
module tkst_dp #(
  parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = tkst_pkg::VALUE_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  tkst_pkg::cmd_t                 cmd,
  input  wire                            in_kind,
  input  wire [tkst_pkg::DATA_W-1:0]     in_value,
  input  wire [tkst_pkg::RANK_W-1:0]     in_rank,
  output logic                           out_kept,
  output logic [tkst_pkg::COUNT_W-1:0]   out_count,
  output logic [tkst_pkg::DATA_W-1:0]    out_value,
  output logic                           out_rvalid
);
  import tkst_pkg::*;

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;
  localparam int WW   = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

  logic                   kind_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [RANK_W-1:0]      rank_r;

  logic [VALUE_WIDTH-1:0] entries_r [TABLE_DEPTH];
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;

  logic [VALUE_WIDTH-1:0] shifted [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ge;
  logic                   full;
  logic                   kept;
  logic [WW-1:0]          value_wide;
  logic [CMPW-1:0]        rank_ext;
  logic [CMPW-1:0]        count_ext;
  logic [IW-1:0]          rank_idx;
  logic                   rvalid;
  logic [WW-1:0]          rd_wide;

  logic                   kept_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic [DATA_W-1:0]      out_value_r;
  logic                   rvalid_r;

  assign value_wide = WW'(in_value);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_kind;
      val_r  <= value_wide[VALUE_WIDTH-1:0];
      rank_r <= in_rank;
    end
  end

  // compare-and-shift cells: entries at or above the new value stay,
  // the first cell below takes it and the rest move down one place
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ge[i] = (CW'(i) < count_r) && (entries_r[i] >= val_r);
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ge[i]) begin
        shifted[i] = entries_r[i];
      end else if (i == 0) begin
        shifted[i] = val_r;
      end else if (ge[i-1]) begin
        shifted[i] = val_r;
      end else begin
        shifted[i] = entries_r[i-1];
      end
    end
  end

  assign full = (count_r == CW'(TABLE_DEPTH));
  assign kept = (kind_r == KIND_INSERT) && (!full || !ge[TABLE_DEPTH-1]);

  always_comb begin
    count_nxt = count_r;
    if (kept && !full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  assign rank_ext  = CMPW'(rank_r);
  assign count_ext = CMPW'(count_nxt);
  assign rank_idx  = rank_ext[IW-1:0];
  assign rvalid    = (kind_r == KIND_READ) && (rank_ext < count_ext);
  assign rd_wide   = rvalid ? WW'(entries_r[rank_idx]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && kept) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entries_r[i] <= shifted[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kept_r      <= kept;
      out_count_r <= count_ext[COUNT_W-1:0];
      out_value_r <= rd_wide[DATA_W-1:0];
      rvalid_r    <= rvalid;
    end
  end

  assign out_kept   = kept_r;
  assign out_count  = out_count_r;
  assign out_value  = out_value_r;
  assign out_rvalid = rvalid_r;

endmodule
`default_nettype wire

// ----- design/tkst_checker.sv -----
`default_nettype none
module tkst_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no second word taken right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous word still in work");

  // an insert never reports a read hit
  a_kept_not_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[21])
    else $error("kept and ranked_valid both set");

  // a missed or absent read returns zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[21] |-> out_tdata[20:5] == 16'd0)
    else $error("ranked_value nonzero without ranked_valid");

endmodule

bind top_k_score_table_top tkst_checker u_tkst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tkst_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct {
    logic                kind;
    logic [DATA_W-1:0]   value;
    logic [RANK_W-1:0]   rank;
  } table_op_t;

  typedef struct {
    logic                kept;
    logic [COUNT_W-1:0]  count;
    logic [DATA_W-1:0]   value;
    logic                valid;
  } table_reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tuser = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;

  // shadow of the score table, largest first
  logic [DATA_W-1:0]  shadow_scores [DEPTH];
  int                 shadow_count = 0;

  table_op_t     op_q[$];
  table_reply_t  reply_q[$];
  int            ops_queued = 0;
  int            ops_taken = 0;
  int            errors = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  logic          in_took = 1'b0;

  top_k_score_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d (reply %0d)", field, got, want,
             ops_taken - reply_q.size());
    errors++;
  endtask

  // apply one op to the shadow table and work out the reply word
  task automatic rank_table_update(input table_op_t op, output table_reply_t r);
    int slot;
    r = '{kept: 1'b0, count: '0, value: '0, valid: 1'b0};
    if (op.kind == KIND_INSERT) begin
      slot = -1;
      if (shadow_count < DEPTH) begin
        slot = shadow_count;
        shadow_count++;
      end else if (op.value > shadow_scores[DEPTH-1]) begin
        slot = DEPTH - 1;
      end
      if (slot >= 0) begin
        // ties stay ahead of the newcomer
        while (slot > 0 && shadow_scores[slot-1] < op.value) begin
          shadow_scores[slot] = shadow_scores[slot-1];
          slot--;
        end
        shadow_scores[slot] = op.value;
        r.kept = 1'b1;
      end
    end else if (int'(op.rank) < shadow_count) begin
      r.value = shadow_scores[op.rank];
      r.valid = 1'b1;
    end
    r.count = shadow_count[COUNT_W-1:0];
  endtask

  always @(negedge clk) begin : driver
    table_op_t op;
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (op_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        op = op_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, op.rank, op.value};
        in_tuser <= op.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    table_reply_t got, want, pred;
    table_op_t seen;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got.kept  = out_tdata[0];
        got.count = out_tdata[4:1];
        got.value = out_tdata[20:5];
        got.valid = out_tdata[21];
        if (reply_q.size() == 0) begin
          $display("unexpected result word 0x%06h", out_tdata);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (got.kept !== want.kept) report_mismatch("kept", got.kept, want.kept);
          if (got.count !== want.count)
            report_mismatch("entry_count", got.count, want.count);
          if (got.value !== want.value)
            report_mismatch("ranked_value", got.value, want.value);
          if (got.valid !== want.valid)
            report_mismatch("ranked_valid", got.valid, want.valid);
        end
      end
      if (in_tvalid && in_tready) begin
        seen.kind  = in_tuser;
        seen.value = in_tdata[DATA_W-1:0];
        seen.rank  = in_tdata[DATA_W +: RANK_W];
        rank_table_update(seen, pred);
        reply_q.push_back(pred);
        ops_taken++;
      end
    end
  end

  task automatic queue_op(input logic kind, input int value, input int rank);
    table_op_t op;
    op.kind  = kind;
    op.value = value[DATA_W-1:0];
    op.rank  = rank[RANK_W-1:0];
    op_q.push_back(op);
    ops_queued++;
  endtask

  task automatic wait_drained();
    while (ops_taken != ops_queued || reply_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int ins_idx;
    int last_val;
    int v;
    int sel;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // empty table reads, extremes, ties, fill, drop on equal, replace smallest
    queue_op(KIND_READ, 16'hffff, 0);
    queue_op(KIND_READ, 0, 13);
    queue_op(KIND_INSERT, 16'h0000, 15);
    queue_op(KIND_INSERT, 16'hffff, 0);
    queue_op(KIND_INSERT, 16'h8000, 0);
    queue_op(KIND_INSERT, 16'h8000, 0);
    queue_op(KIND_READ, 0, 0);
    queue_op(KIND_READ, 0, 3);
    queue_op(KIND_READ, 16'hffff, 4);
    queue_op(KIND_INSERT, 16'h1234, 0);
    queue_op(KIND_INSERT, 16'h00ff, 0);
    queue_op(KIND_INSERT, 16'h5555, 0);
    queue_op(KIND_INSERT, 16'haaaa, 0);
    queue_op(KIND_INSERT, 16'h0001, 0);
    queue_op(KIND_INSERT, 16'h0002, 0);
    queue_op(KIND_INSERT, 16'h0003, 0);
    queue_op(KIND_INSERT, 16'h7fff, 0);
    queue_op(KIND_INSERT, 16'h0f0f, 0);
    queue_op(KIND_INSERT, 16'h8000, 0);
    queue_op(KIND_INSERT, 16'h0000, 0);
    queue_op(KIND_INSERT, 16'h0001, 0);
    queue_op(KIND_READ, 0, 13);
    queue_op(KIND_READ, 0, 1);
    // sender holds off until every reply is back
    wait_drained();

    ins_idx = 0;
    last_val = 16'h8000;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      for (int i = 0; i < 325; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          queue_op(KIND_READ, $urandom, $urandom_range(0, 13));
        end else begin
          sel = $urandom_range(0, 15);
          // a slowly rising floor keeps a good share of inserts landing in the table
          if (sel == 0) v = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
          else if (sel <= 2) v = $urandom_range(0, 16'hffff);
          else if (sel == 3) v = last_val;
          else begin
            v = ins_idx * 60 + $urandom_range(0, 1500);
            if (v > 16'hffff) v = 16'hffff;
          end
          last_val = v;
          ins_idx++;
          queue_op(KIND_INSERT, v, $urandom_range(0, 15));
        end
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
